>>> rtl/core/mfek_pkg.sv
package mfek_pkg;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 72;
	localparam int NODE_W     = 5;
	localparam int CAP_W      = 32;
	localparam int FLOW_W     = 40;
	localparam int MASK_W     = 32;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SINK   = 2'd1;

	localparam logic KIND_ADD_EDGE = 1'b0;
	localparam logic KIND_COMPUTE  = 1'b1;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_SINIT,
		ST_DEQ,
		ST_RD,
		ST_CHK,
		ST_A1I,
		ST_A1R,
		ST_A1C,
		ST_A2I,
		ST_A2RF,
		ST_A2RB,
		ST_A2WB,
		ST_DONE
	} state_t;

endpackage

>>> rtl/core/max_flow_edmonds_karp_unit.sv
// Edmonds-Karp maximum flow over a NODES x NODES residual matrix held in one
// single-port-write, registered-read RAM. After reset the RAM is cleared entry
// by entry, during which no request is taken. An add-edge request (tuser 0)
// is written to the RAM as it is accepted. A compute request (tuser 1) repeats
// a breadth-first search; each augmenting path found is walked from the sink
// once for its bottleneck and once to update the residuals. Each matrix read
// of a compute goes through the one RAM read port. The result holds total
// flow and the source side of the minimum cut.
module max_flow_edmonds_karp_unit #(
	parameter int NODES    = 32,
	parameter int CAP_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// from_node[4:0], to_node[9:5], capacity[41:10], zero fill
	input  logic [mfek_pkg::IN_DATA_W-1:0]     s_tdata,
	// kind
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// total_flow[39:0], cut_mask[71:40]
	output logic [mfek_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                               cfg_we,
	input  logic [mfek_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mfek_pkg::NODE_W-1:0]        cfg_data
);
	import mfek_pkg::*;

	localparam int NW    = $clog2(NODES);
	localparam int QW    = $clog2(NODES + 1);
	localparam int DEPTH = NODES * NODES;
	localparam int AW    = $clog2(DEPTH);
	localparam int RES_W = CAP_BITS + 1;
	localparam int CB    = (CAP_BITS < CAP_W) ? CAP_BITS : CAP_W;
	localparam int SUM_W = ((RES_W > FLOW_W) ? RES_W : FLOW_W) + 1;
	localparam int MN    = (NODES < MASK_W) ? NODES : MASK_W;
	localparam logic [RES_W-1:0]  RES_MAX  = '1;
	localparam logic [FLOW_W-1:0] FLOW_MAX = '1;

	state_t state_q, state_d;

	logic [RES_W-1:0]  mem [DEPTH];
	logic [RES_W-1:0]  rdata_q;
	logic [AW-1:0]     raddr, waddr;
	logic              we;
	logic [RES_W-1:0]  wdata;

	logic [AW-1:0]     clr_q;
	logic [NODE_W-1:0] src_q, snk_q;
	logic [NODES-1:0]  reached_q;
	logic [NW-1:0]     parent_q [NODES];
	logic [NW-1:0]     queue_q [NODES];
	logic [QW-1:0]     head_q, tail_q;
	logic [NW-1:0]     cur_i_q, j_q, cur_q;
	logic [RES_W-1:0]  gain_q;
	logic [FLOW_W-1:0] flow_q;
	logic              out_valid_q;
	logic [FLOW_W-1:0] out_flow_q;
	logic [MASK_W-1:0] out_mask_q;

	logic              in_acc, src_ok, hit, j_last, j_snk, cur_src, head_ok, edge_ok, out_free;
	logic [NODE_W-1:0] from_n, to_n;
	logic [NW-1:0]     src_n, snk_n, par_cur;
	logic [SUM_W-1:0]  flow_sum;
	logic [RES_W:0]    back_sum;
	logic [MASK_W-1:0] mask_w;

	function automatic logic [AW-1:0] ad(input logic [NW-1:0] a, input logic [NW-1:0] b);
		ad = AW'(a) * AW'(NODES) + AW'(b);
	endfunction

	assign in_acc   = s_tvalid && s_tready;
	assign from_n   = s_tdata[4:0];
	assign to_n     = s_tdata[9:5];
	assign edge_ok  = (int'(from_n) < NODES) && (int'(to_n) < NODES);
	assign src_ok   = int'(src_q) < NODES;
	assign src_n    = NW'(src_q);
	assign snk_n    = NW'(snk_q);
	assign par_cur  = parent_q[cur_q];
	assign hit      = !reached_q[j_q] && (rdata_q != '0);
	assign j_last   = j_q == NW'(NODES - 1);
	assign j_snk    = 7'(j_q) == 7'(snk_q);
	assign cur_src  = cur_q == src_n;
	assign head_ok  = head_q < tail_q;
	assign out_free = !out_valid_q || m_tready;
	assign flow_sum = SUM_W'(flow_q) + SUM_W'(gain_q);
	assign back_sum = {1'b0, rdata_q} + {1'b0, gain_q};

	always_comb begin
		mask_w = '0;
		for (int n = 0; n < MN; n++) begin
			mask_w[n] = reached_q[n];
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_mask_q, out_flow_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR:   if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (in_acc && s_tuser == KIND_COMPUTE) state_d = ST_SINIT;
			ST_SINIT: state_d = src_ok ? ST_DEQ : ST_DONE;
			ST_DEQ:   state_d = head_ok ? ST_RD : ST_DONE;
			ST_RD:    state_d = ST_CHK;
			ST_CHK: begin
				if (hit && j_snk) state_d = ST_A1I;
				else if (j_last) state_d = ST_DEQ;
				else state_d = ST_RD;
			end
			ST_A1I:   state_d = ST_A1R;
			ST_A1R:   state_d = cur_src ? ST_A2I : ST_A1C;
			ST_A1C:   state_d = ST_A1R;
			ST_A2I:   state_d = ST_A2RF;
			ST_A2RF:  state_d = cur_src ? ST_SINIT : ST_A2RB;
			ST_A2RB:  state_d = ST_A2WB;
			ST_A2WB:  state_d = ST_A2RF;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = '0;
		case (state_q)
			ST_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			ST_IDLE: begin
				we    = in_acc && s_tuser == KIND_ADD_EDGE && edge_ok;
				waddr = ad(NW'(from_n), NW'(to_n));
				wdata = RES_W'(s_tdata[10 +: CB]);
			end
			ST_RD:   raddr = ad(cur_i_q, j_q);
			ST_A1R:  raddr = ad(par_cur, cur_q);
			ST_A2RF: raddr = ad(par_cur, cur_q);
			ST_A2RB: begin
				raddr = ad(cur_q, par_cur);
				we    = 1'b1;
				waddr = ad(par_cur, cur_q);
				wdata = rdata_q - gain_q;
			end
			ST_A2WB: begin
				we    = 1'b1;
				waddr = ad(cur_q, par_cur);
				wdata = back_sum[RES_W] ? RES_MAX : back_sum[RES_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			src_q       <= '0;
			snk_q       <= NODE_W'(31);
			reached_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == CFG_SOURCE) src_q <= cfg_data;
			if (cfg_we && cfg_index == CFG_SINK) snk_q <= cfg_data;
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (m_tvalid && m_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLR: clr_q <= clr_q + 1'b1;
				ST_SINIT: begin
					reached_q <= src_ok ? (NODES'(1) << src_n) : '0;
					head_q    <= '0;
					tail_q    <= src_ok ? QW'(1) : '0;
				end
				ST_DEQ: if (head_ok) head_q <= head_q + 1'b1;
				ST_CHK: if (hit) begin
					reached_q[j_q] <= 1'b1;
					if (int'(tail_q) < NODES) tail_q <= tail_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_acc) flow_q <= '0;
			ST_SINIT: if (src_ok) begin
				parent_q[src_n] <= src_n;
				queue_q[0]      <= src_n;
			end
			ST_DEQ: begin
				cur_i_q <= queue_q[head_q[NW-1:0]];
				j_q     <= '0;
			end
			ST_CHK: begin
				if (hit) begin
					parent_q[j_q] <= cur_i_q;
					if (int'(tail_q) < NODES) queue_q[tail_q[NW-1:0]] <= j_q;
				end
				if (!(hit && j_snk) && !j_last) j_q <= j_q + 1'b1;
			end
			ST_A1I: begin
				gain_q <= RES_MAX;
				cur_q  <= snk_n;
			end
			ST_A1C: begin
				if (rdata_q < gain_q) gain_q <= rdata_q;
				cur_q <= par_cur;
			end
			ST_A2I:  cur_q <= snk_n;
			ST_A2RF: if (cur_src) begin
				flow_q <= (flow_sum > SUM_W'(FLOW_MAX)) ? FLOW_MAX : flow_sum[FLOW_W-1:0];
			end
			ST_A2WB: cur_q <= par_cur;
			ST_DONE: if (out_free) begin
				out_flow_q <= flow_q;
				out_mask_q <= mask_w;
			end
			default: ;
		endcase
	end

	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(tail_q) <= NODES)
		else $error("queue tail beyond node count");

	a_reach_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEQ || state_q == ST_RD || state_q == ST_CHK)
		|-> $countones(reached_q) == int'(tail_q))
		else $error("reached set and queue disagree");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_A2RB || state_q == ST_A2WB) |-> !s_tready && we)
		else $error("update step without write");

endmodule

>>> tb/sv/mfek_flow_checker.sv
`timescale 1ns / 1ps

module mfek_flow_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [mfek_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                            s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [mfek_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_we,
	input  logic [mfek_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mfek_pkg::NODE_W-1:0]     cfg_data,
	output int                              fail_count,
	output int                              pending,
	output int                              results_seen
);
	import mfek_pkg::*;

	localparam int EXP_DEPTH = 16;

	typedef struct packed {
		logic [FLOW_W-1:0] flow;
		logic [MASK_W-1:0] cut;
	} flow_result_t;

	logic [CAP_W:0]    resid [0:31][0:31];
	logic [NODE_W-1:0] src_node;
	logic [NODE_W-1:0] snk_node;
	flow_result_t      exp_fifo [EXP_DEPTH];
	int                wr_ptr, rd_ptr;

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		fail_count++;
	endtask

	// Repeated BFS for shortest augmenting paths; residuals are updated in place.
	task automatic solve_max_flow(output logic [FLOW_W-1:0] flow, output logic [MASK_W-1:0] cut);
		logic [31:0]       seen;
		logic [NODE_W-1:0] via [0:31];
		logic [NODE_W-1:0] fifo [0:31];
		logic [CAP_W:0]    gain;
		logic [CAP_W:0]    back;
		logic [CAP_W+1:0]  sum;
		logic [FLOW_W:0]   acc;
		int                hd, tl, k, steps;
		logic [NODE_W-1:0] i, j;
		bit                found;
		flow = '0;
		while (1) begin
			seen = '0;
			seen[src_node] = 1'b1;
			via[src_node] = src_node;
			fifo[0] = src_node;
			hd = 0;
			tl = 1;
			found = 0;
			while (hd < tl && !found) begin
				i = fifo[hd];
				hd++;
				for (k = 0; k < 32 && !found; k++) begin
					if (!seen[k] && resid[i][k] != '0) begin
						seen[k] = 1'b1;
						via[k] = i;
						if (tl < 32) begin
							fifo[tl] = k[NODE_W-1:0];
							tl++;
						end
						if (k == snk_node)
							found = 1;
					end
				end
			end
			cut = seen;
			if (!found)
				break;
			gain = '1;
			j = snk_node;
			steps = 0;
			while (j != src_node && steps < 32) begin
				i = via[j];
				if (resid[i][j] < gain)
					gain = resid[i][j];
				j = i;
				steps++;
			end
			j = snk_node;
			steps = 0;
			while (j != src_node && steps < 32) begin
				i = via[j];
				back = resid[j][i];
				resid[i][j] = resid[i][j] - gain;
				sum = {1'b0, back} + {1'b0, gain};
				resid[j][i] = sum[CAP_W+1] ? '1 : sum[CAP_W:0];
				j = i;
				steps++;
			end
			acc = {1'b0, flow} + gain;
			flow = acc[FLOW_W] ? '1 : acc[FLOW_W-1:0];
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		flow_result_t want, got;
		if (!arst_n) begin
			for (int a = 0; a < 32; a++)
				for (int b = 0; b < 32; b++)
					resid[a][b] = '0;
			src_node = 0;
			snk_node = 31;
			wr_ptr = 0;
			rd_ptr = 0;
			pending = 0;
			fail_count = 0;
			results_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SOURCE: src_node = cfg_data;
					CFG_SINK:   snk_node = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == KIND_COMPUTE) begin
					solve_max_flow(want.flow, want.cut);
					if (wr_ptr - rd_ptr >= EXP_DEPTH) begin
						report_mismatch("too many results outstanding");
					end else begin
						exp_fifo[wr_ptr % EXP_DEPTH] = want;
						wr_ptr++;
					end
				end else begin
					resid[s_tdata[4:0]][s_tdata[9:5]] = {1'b0, s_tdata[41:10]};
				end
			end
			if (m_tvalid && m_tready) begin
				got.flow = m_tdata[39:0];
				got.cut  = m_tdata[71:40];
				results_seen++;
				if (wr_ptr == rd_ptr) begin
					report_mismatch($sformatf("result with no request pending: %h", m_tdata));
				end else begin
					want = exp_fifo[rd_ptr % EXP_DEPTH];
					rd_ptr++;
					if (got.flow !== want.flow)
						report_mismatch($sformatf("total_flow %h, expected %h", got.flow, want.flow));
					if (got.cut !== want.cut)
						report_mismatch($sformatf("cut_mask %h, expected %h", got.cut, want.cut));
				end
			end
			pending = wr_ptr - rd_ptr;
		end
	end

endmodule

>>> tb/sv/max_flow_edmonds_karp_unit_test.sv
`timescale 1ns / 1ps

module max_flow_edmonds_karp_unit_test;
	import mfek_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [NODE_W-1:0]     cfg_data = '0;

	int fail_count, pending, results_seen;
	int send_idle = 0, recv_idle = 0;
	int sent = 0, computes = 0, settings = 0;
	logic [NODE_W-1:0] cur_src = 5'd0, cur_snk = 5'd31;

	max_flow_edmonds_karp_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	mfek_flow_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .results_seen(results_seen)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		#200_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	task automatic send_request(input logic kind, input logic [4:0] from, input logic [4:0] to,
			input logic [31:0] cap);
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {6'd0, cap, to, from};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
		if (kind == KIND_COMPUTE)
			computes++;
	endtask

	task automatic put_edge(input logic [4:0] from, input logic [4:0] to, input logic [31:0] cap);
		send_request(KIND_ADD_EDGE, from, to, cap);
	endtask

	task automatic run_compute();
		send_request(KIND_COMPUTE, 5'($urandom), 5'($urandom), $urandom);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_terminals(input logic [4:0] src, input logic [4:0] snk,
			input logic [CFG_IDX_W-1:0] spare);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SOURCE;
		cfg_data <= src;
		@(posedge clk);
		cfg_index <= CFG_SINK;
		cfg_data <= snk;
		@(posedge clk);
		cfg_index <= spare;
		cfg_data <= NODE_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_src = src;
		cur_snk = snk;
		settings++;
	endtask

	function automatic logic [4:0] pick_node();
		int r;
		r = $urandom_range(9);
		if (r < 3)
			return cur_src;
		if (r < 5)
			return cur_snk;
		return 5'($urandom_range(31));
	endfunction

	function automatic logic [31:0] pick_cap();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return $urandom_range(1, 16) << 16;
			3: return $urandom_range(1, 255);
			default: return $urandom;
		endcase
	endfunction

	// Mostly small graphs built around the current terminals, then a compute.
	task automatic random_traffic(input int n_items);
		int done_items, edges;
		done_items = 0;
		while (done_items < n_items) begin
			if ($urandom_range(99) < 15) begin
				run_compute();
				done_items++;
			end else begin
				edges = $urandom_range(1, 6);
				repeat (edges)
					put_edge(pick_node(), pick_node(), pick_cap());
				run_compute();
				done_items += edges + 1;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 29;
		recv_idle = 74;
		set_terminals(5'd0, 5'd31, CFG_SPARE_LO);
		put_edge(5'd0, 5'd1, 32'hFFFF_FFFF);
		put_edge(5'd1, 5'd0, 32'hFFFF_FFFF);
		put_edge(5'd1, 5'd31, 32'hFFFF_FFFF);
		put_edge(5'd0, 5'd31, 32'h0000_0001);
		put_edge(5'd5, 5'd5, 32'h0001_0000);
		put_edge(5'd2, 5'd3, 32'h0000_0000);
		put_edge(5'd0, 5'd2, 32'h0003_8000);
		put_edge(5'd2, 5'd31, 32'h0001_0000);
		run_compute();
		// reverse entry 1->0 now near its ceiling; a second push saturates it
		put_edge(5'd0, 5'd1, 32'hFFFF_FFFF);
		put_edge(5'd1, 5'd31, 32'hFFFF_FFFF);
		run_compute();
		run_compute();
		put_edge(5'd31, 5'd30, 32'hAAAA_5555);
		put_edge(5'd30, 5'd31, 32'h5555_AAAA);
		put_edge(5'd31, 5'd0, 32'h0001_0000);
		run_compute();
		random_traffic(30);
		settle();

		send_idle = 74;
		recv_idle = 29;
		set_terminals(5'd31, 5'd0, CFG_SPARE_HI);
		random_traffic(45);
		settle();

		send_idle = 0;
		recv_idle = 0;
		set_terminals(5'd9, 5'd9, CFG_SPARE_LO);
		put_edge(5'd9, 5'd12, 32'h0002_0000);
		put_edge(5'd12, 5'd9, 32'h0001_0000);
		run_compute();
		settle();
		set_terminals(5'd4, 5'd17, CFG_SPARE_HI);
		random_traffic(45);
		settle();
		repeat (40) @(posedge clk);

		$display("covered %0d requests, %0d computes, %0d results, %0d terminal settings",
			sent, computes, results_seen, settings);
		$display("idle profiles: sender-heavy, receiver-heavy, none");
		if (fail_count == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
